### rtl/core/hex_echo_stack_responder_core_defines.svh
// Assertion macros shared by the checker of the hex echo stack responder.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef HEX_ECHO_STACK_RESPONDER_CORE_DEFINES_SVH
`define HEX_ECHO_STACK_RESPONDER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HES_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hes check failed");

// Next-cycle implication, checked out of reset.
`define HES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hes check failed");

`endif

### rtl/core/hes_pkg.sv
// Types, codes and character tables of the hex echo stack responder.
// No dependencies; imported by every module of the block.
package hes_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } hes_in_t;

  typedef struct packed {
    logic [7:0] tx_char;
    logic       stack_nonempty;
  } hes_out_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } hes_mem_ctl_t;

  typedef enum logic [2:0] {
    PH_ZERO,
    PH_X,
    PH_HI,
    PH_LO,
    PH_TAIL
  } hes_phase_e;

  localparam logic       KIND_RX     = 1'b0;
  localparam logic       KIND_TICK   = 1'b1;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_X      = 8'h78;
  localparam logic [7:0] HEX_NUM_OFS = 8'd48;
  localparam logic [7:0] HEX_LTR_OFS = 8'd87;
  localparam logic [4:0] TAIL_LEN    = 5'd16;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    return (nib < 4'd10) ? (ext + HEX_NUM_OFS) : (ext + HEX_LTR_OFS);
  endfunction

  // " data received\r\n"
  function automatic logic [7:0] tail_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h20;
      4'd1:    ch = 8'h64;
      4'd2:    ch = 8'h61;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h61;
      4'd5:    ch = 8'h20;
      4'd6:    ch = 8'h72;
      4'd7:    ch = 8'h65;
      4'd8:    ch = 8'h63;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h69;
      4'd11:   ch = 8'h76;
      4'd12:   ch = 8'h65;
      4'd13:   ch = 8'h64;
      4'd14:   ch = 8'h0D;
      default: ch = 8'h0A;
    endcase
    return ch;
  endfunction

endpackage

### rtl/core/hes_stack_mem.sv
// Byte stack storage: one write port, one read port with registered data.
// Depends on hes_pkg for the port control struct.
module hes_stack_mem import hes_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32,
  localparam int unsigned IdxW = $clog2(STACK_DEPTH)
) (
  input  logic            clk_i,
  input  hes_mem_ctl_t    ctl_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [7:0]      wr_data_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0] mem_q [STACK_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/hes_reply_ctrl.sv
// Stack pointer, reply sequencer and output register.
// Depends on hes_pkg; drives the ports of hes_stack_mem.
module hes_reply_ctrl import hes_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32,
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1),
  localparam int unsigned IdxW = $clog2(STACK_DEPTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  hes_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output hes_out_t        out_data_o,
  output hes_mem_ctl_t    mem_ctl_o,
  output logic [IdxW-1:0] wr_addr_o,
  output logic [7:0]      wr_data_o,
  output logic [IdxW-1:0] rd_addr_o,
  input  logic [7:0]      rd_data_i
);

  hes_phase_e      phase_q, phase_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] count_m1;
  logic [4:0]      tail_q, tail_d;
  logic [7:0]      latched_q, latched_d;
  logic            rd_pend_q, rd_pend_d;
  logic            out_valid_q, out_valid_d;
  hes_out_t        out_data_q, out_data_d;
  logic            out_free;
  logic            accept;
  logic            full;
  logic            nonempty;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = rd_pend_q || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(STACK_DEPTH));
  assign nonempty   = (count_q != '0);
  assign count_m1   = count_q - 1'b1;

  assign wr_addr_o = count_q[IdxW-1:0];
  assign wr_data_o = in_data_i.rx_byte;
  assign rd_addr_o = count_m1[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ZERO;
      count_q     <= '0;
      tail_q      <= '0;
      latched_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      tail_q      <= tail_d;
      latched_q   <= latched_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    tail_d      = tail_q;
    latched_d   = latched_q;
    rd_pend_d   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    mem_ctl_o   = '0;

    if (rd_pend_q) begin
      // top byte is back from the stack: latch it and send the high digit
      latched_d   = rd_data_i;
      out_valid_d = 1'b1;
      out_data_d  = '{tx_char: hex_digit(rd_data_i[7:4]), stack_nonempty: nonempty};
      phase_d     = PH_LO;
    end else if (accept) begin
      if (in_data_i.kind == KIND_RX) begin
        // drop the byte when the stack is full
        if (!full) begin
          mem_ctl_o.wr_en = 1'b1;
          count_d         = count_q + 1'b1;
        end
      end else if (nonempty) begin
        unique case (phase_q)
          PH_X: begin
            out_valid_d = 1'b1;
            out_data_d  = '{tx_char: CHAR_X, stack_nonempty: nonempty};
            phase_d     = PH_HI;
          end
          PH_HI: begin
            mem_ctl_o.rd_en = 1'b1;
            rd_pend_d       = 1'b1;
          end
          PH_LO: begin
            out_valid_d = 1'b1;
            out_data_d  = '{tx_char: hex_digit(latched_q[3:0]), stack_nonempty: nonempty};
            phase_d     = PH_TAIL;
          end
          PH_TAIL: begin
            if (tail_q >= TAIL_LEN) begin
              // end of reply: pop the current top, emit nothing
              tail_d  = '0;
              count_d = count_m1;
              phase_d = PH_ZERO;
            end else begin
              out_valid_d = 1'b1;
              out_data_d  = '{tx_char: tail_char(tail_q[3:0]), stack_nonempty: nonempty};
              tail_d      = tail_q + 1'b1;
            end
          end
          default: begin
            out_valid_d = 1'b1;
            out_data_d  = '{tx_char: CHAR_ZERO, stack_nonempty: nonempty};
            phase_d     = PH_X;
          end
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/core/hex_echo_stack_responder_core.sv
// Channel   | Payload      | Handshake               | Transaction
// in        | hes_in_t     | in_valid_i / in_stall_o | received byte or transmit tick
// out       | hes_out_t    | out_valid_o / out_stall_i | one reply character
//
// The tick that sends the high hex digit waits on the registered stack read.
// The input stalls while that read is in flight and while a character is held
// and stalled on the output. Reset clears the stack count, reply sequencer and
// output valid; stack contents are left as they are.
// Top level of the hex echo stack responder; depends on hes_pkg,
// hes_stack_mem and hes_reply_ctrl.
module hex_echo_stack_responder_core import hes_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  hes_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output hes_out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(STACK_DEPTH);

  hes_mem_ctl_t    mem_ctl;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] rd_addr;
  logic [7:0]      wr_data;
  logic [7:0]      rd_data;

  hes_reply_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .mem_ctl_o  (mem_ctl),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  hes_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_mem (
    .clk_i    (clk_i),
    .ctl_i    (mem_ctl),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

endmodule

### rtl/core/hes_checker.sv
// Port-level checks of the hex echo stack responder, bound to the top level.
// Depends on hes_pkg and the macros of hex_echo_stack_responder_core_defines.svh.
`include "hex_echo_stack_responder_core_defines.svh"

module hes_port_checker import hes_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input hes_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input hes_out_t out_data_o
);

  // Hold a stalled transaction on the output.
  `HES_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `HES_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o))
  // A character only goes out while the stack holds a byte.
  `HES_ASSERT_NOW(a_nonempty, out_valid_o, out_data_o.stack_nonempty)
  // Reply characters are plain ASCII.
  `HES_ASSERT_NOW(a_ascii, out_valid_o, out_data_o.tx_char[7] == 1'b0)
  // A received byte never creates a character.
  `HES_ASSERT_NEXT(a_push_silent,
    in_valid_i && !in_stall_o && (in_data_i.kind == KIND_RX) && !out_valid_o, !out_valid_o)

endmodule

bind hex_echo_stack_responder_core hes_port_checker u_checker (.*);
